// ----- rtl/qrs_pkg.sv -----
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_W          = 34;
  localparam int KIND_W         = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_REAL    = 2'd0,
    KIND_COMPLEX = 2'd1,
    KIND_DEGEN   = 2'd2
  } root_kind_t;

endpackage

// ----- rtl/qrs_isqrt_pipe.sv -----
module qrs_isqrt_pipe #(
  parameter int R_W    = 33,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*R_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [R_W-1:0]    out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic [2*R_W-1:0]  rad_r  [0:R_W];
  logic [R_W-1:0]    root_r [0:R_W];
  logic [R_W+1:0]    rem_r  [0:R_W];
  logic [SIDE_W-1:0] side_r [0:R_W];
  logic              vld_r  [0:R_W];

  assign rad_r[0]  = in_rad;
  assign root_r[0] = '0;
  assign rem_r[0]  = '0;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_valid;

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic [R_W+3:0] rem_sh;
    logic [R_W+3:0] trial;
    logic           ge;
    logic [R_W+3:0] rem_sub;

    assign rem_sh  = {rem_r[k], rad_r[k][2*R_W-1 -: 2]};
    assign trial   = {2'b00, root_r[k], 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1]  <= {rad_r[k][2*R_W-3:0], 2'b00};
        root_r[k+1] <= {root_r[k][R_W-2:0], ge};
        rem_r[k+1]  <= ge ? rem_sub[R_W+1:0] : rem_sh[R_W+1:0];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[R_W];
  assign out_root  = root_r[R_W];
  assign out_side  = side_r[R_W];

endmodule

// ----- rtl/qrs_div_pipe.sv -----
module qrs_div_pipe #(
  parameter int N_W    = 34,
  parameter int V_W    = 17,
  parameter int SIDE_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    in_num_one,
  input  logic [N_W-1:0]    in_num_two,
  input  logic [V_W-1:0]    in_dvs,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [N_W-1:0]    out_quo_one,
  output logic [N_W-1:0]    out_quo_two,
  output logic [SIDE_W-1:0] out_side
);

  logic [N_W-1:0]    num1_r [0:N_W];
  logic [N_W-1:0]    num2_r [0:N_W];
  logic [N_W-1:0]    quo1_r [0:N_W];
  logic [N_W-1:0]    quo2_r [0:N_W];
  logic [V_W:0]      rem1_r [0:N_W];
  logic [V_W:0]      rem2_r [0:N_W];
  logic [V_W-1:0]    dvs_r  [0:N_W];
  logic [SIDE_W-1:0] side_r [0:N_W];
  logic              vld_r  [0:N_W];

  assign num1_r[0] = in_num_one;
  assign num2_r[0] = in_num_two;
  assign quo1_r[0] = '0;
  assign quo2_r[0] = '0;
  assign rem1_r[0] = '0;
  assign rem2_r[0] = '0;
  assign dvs_r[0]  = in_dvs;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_valid;

  for (genvar k = 0; k < N_W; k++) begin : g_stage
    logic [V_W+1:0] sh1;
    logic [V_W+1:0] sh2;
    logic [V_W+1:0] dv;
    logic [V_W+1:0] sub1;
    logic [V_W+1:0] sub2;
    logic           ge1;
    logic           ge2;

    assign sh1  = {rem1_r[k], num1_r[k][N_W-1]};
    assign sh2  = {rem2_r[k], num2_r[k][N_W-1]};
    assign dv   = {2'b00, dvs_r[k]};
    assign ge1  = (sh1 >= dv);
    assign ge2  = (sh2 >= dv);
    assign sub1 = sh1 - dv;
    assign sub2 = sh2 - dv;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num1_r[k+1] <= {num1_r[k][N_W-2:0], 1'b0};
        num2_r[k+1] <= {num2_r[k][N_W-2:0], 1'b0};
        quo1_r[k+1] <= {quo1_r[k][N_W-2:0], ge1};
        quo2_r[k+1] <= {quo2_r[k][N_W-2:0], ge2};
        rem1_r[k+1] <= ge1 ? sub1[V_W:0] : sh1[V_W:0];
        rem2_r[k+1] <= ge2 ? sub2[V_W:0] : sh2[V_W:0];
        dvs_r[k+1]  <= dvs_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid   = vld_r[N_W];
  assign out_quo_one = quo1_r[N_W];
  assign out_quo_two = quo2_r[N_W];
  assign out_side    = side_r[N_W];

endmodule

// ----- rtl/quadratic_root_solver_unit.sv -----
// Quadratic root solver taking one request per cycle unless out_tready stalls it.
// The input channel carries one request per equation: in_tdata holds coef_a,
// coef_b and coef_c, signed, from the lowest bit up.
// The output channel returns one result per request in the same order:
// out_tdata holds the real and imaginary parts of both roots with FRAC_BITS
// fraction bits, and out_tuser holds the root kind (real, complex, degenerate).
// The pipeline runs through registers s1 to s3, R_W = COEF_WIDTH + FRAC_BITS + 1
// square root digit stages, register s4, N_W = COEF_WIDTH + FRAC_BITS + 2
// quotient bit stages and the output register.
// Throughput is one request per cycle, set by the one-digit-per-stage square
// root and divider pipelines, whenever out_tready does not stall the pipeline.
// When the receiver holds out_tready low with a result waiting, the whole
// pipeline holds and in_tready falls in the same cycle; nothing is dropped.
// Synchronous reset clears all valid bits, so the block comes out of reset
// empty and ready.
module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // coef_a, coef_b, coef_c
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // root_one_real, root_one_imag, root_two_real, root_two_imag
  output logic [((4*qrs_pkg::OUT_W+7)/8)*8-1:0]   out_tdata,
  // root_kind
  output logic [qrs_pkg::KIND_W-1:0]              out_tuser
);

  import qrs_pkg::*;

  localparam int CW      = COEF_WIDTH;
  localparam int FB      = FRAC_BITS;
  localparam int OD_W    = ((4*OUT_W+7)/8)*8;
  localparam int D_W     = 2*CW+3;
  localparam int MAG_W   = 2*CW+2;
  localparam int R_W     = CW+FB+1;
  localparam int NB_W    = CW+FB+1;
  localparam int V_W     = CW+1;
  localparam int SW      = CW+FB+3;
  localparam int N_W     = SW-1;
  localparam int SIDE1_W = NB_W+V_W+3;
  localparam int SIDE2_W = 2+KIND_W;
  localparam int EW      = ((SW > OUT_W) ? SW : OUT_W)+1;
  localparam logic [EW-1:0] SAT_MAX = {{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic [EW-1:0] SAT_MIN = {{(EW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic                 s1_vld_r;
  logic signed [CW-1:0] s1_a_r, s1_b_r, s1_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r <= in_tdata[CW-1:0];
      s1_b_r <= in_tdata[2*CW-1:CW];
      s1_c_r <= in_tdata[3*CW-1:2*CW];
    end
  end

  logic                   s2_vld_r;
  logic signed [2*CW-1:0] s2_bb_r, s2_ac_r;
  logic [NB_W-1:0]        s2_nb_r;
  logic [V_W-1:0]         s2_den_r;
  logic                   s2_aneg_r, s2_azero_r;
  logic [NB_W-1:0]        nb_nxt;
  logic [V_W-1:0]         a_ext;

  assign nb_nxt = -({{(NB_W-CW){s1_b_r[CW-1]}}, s1_b_r} << FB);
  assign a_ext  = {s1_a_r[CW-1], s1_a_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bb_r    <= s1_b_r * s1_b_r;
      s2_ac_r    <= s1_a_r * s1_c_r;
      s2_nb_r    <= nb_nxt;
      s2_den_r   <= s1_a_r[CW-1] ? V_W'(-a_ext) << 1 : a_ext << 1;
      s2_aneg_r  <= s1_a_r[CW-1];
      s2_azero_r <= (s1_a_r == '0);
    end
  end

  logic                  s3_vld_r;
  logic [MAG_W-1:0]      s3_mag_r;
  logic [NB_W-1:0]       s3_nb_r;
  logic [V_W-1:0]        s3_den_r;
  logic                  s3_aneg_r, s3_azero_r, s3_dneg_r;
  logic signed [D_W-1:0] d_val;
  logic [D_W-1:0]        d_abs;

  assign d_val = D_W'(s2_bb_r) - (D_W'(s2_ac_r) <<< 2);
  assign d_abs = d_val[D_W-1] ? -d_val : d_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mag_r   <= d_abs[MAG_W-1:0];
      s3_dneg_r  <= d_val[D_W-1];
      s3_nb_r    <= s2_nb_r;
      s3_den_r   <= s2_den_r;
      s3_aneg_r  <= s2_aneg_r;
      s3_azero_r <= s2_azero_r;
    end
  end

  logic               sq_vld;
  logic [R_W-1:0]     sq_root;
  logic [SIDE1_W-1:0] sq_side;

  qrs_isqrt_pipe #(
    .R_W    (R_W),
    .SIDE_W (SIDE1_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .in_rad    ({s3_mag_r, {(2*FB){1'b0}}}),
    .in_side   ({s3_nb_r, s3_den_r, s3_aneg_r, s3_dneg_r, s3_azero_r}),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic [NB_W-1:0] q_nb;
  logic [V_W-1:0]  q_den;
  logic            q_aneg, q_dneg, q_azero;
  logic [SW-1:0]   nb_x, s_x, n1, n2, n1_abs, n2_abs;
  root_kind_t      kind_nxt;

  assign {q_nb, q_den, q_aneg, q_dneg, q_azero} = sq_side;
  assign nb_x   = {{(SW-NB_W){q_nb[NB_W-1]}}, q_nb};
  assign s_x    = {{(SW-R_W){1'b0}}, sq_root};
  assign n1     = q_dneg ? nb_x : nb_x + s_x;
  assign n2     = q_dneg ? s_x : nb_x - s_x;
  assign n1_abs = n1[SW-1] ? -n1 : n1;
  assign n2_abs = n2[SW-1] ? -n2 : n2;

  always_comb begin
    if (q_azero) begin
      kind_nxt = KIND_DEGEN;
    end else if (q_dneg) begin
      kind_nxt = KIND_COMPLEX;
    end else begin
      kind_nxt = KIND_REAL;
    end
  end

  logic               s4_vld_r;
  logic [N_W-1:0]     s4_n1_r, s4_n2_r;
  logic [V_W-1:0]     s4_den_r;
  logic [SIDE2_W-1:0] s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_n1_r   <= n1_abs[N_W-1:0];
      s4_n2_r   <= n2_abs[N_W-1:0];
      s4_den_r  <= q_den;
      s4_side_r <= {n1[SW-1] ^ q_aneg, n2[SW-1] ^ q_aneg, kind_nxt};
    end
  end

  logic               dv_vld;
  logic [N_W-1:0]     dv_q1, dv_q2;
  logic [SIDE2_W-1:0] dv_side;

  qrs_div_pipe #(
    .N_W    (N_W),
    .V_W    (V_W),
    .SIDE_W (SIDE2_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (s4_vld_r),
    .in_num_one  (s4_n1_r),
    .in_num_two  (s4_n2_r),
    .in_dvs      (s4_den_r),
    .in_side     (s4_side_r),
    .out_valid   (dv_vld),
    .out_quo_one (dv_q1),
    .out_quo_two (dv_q2),
    .out_side    (dv_side)
  );

  function automatic logic [OUT_W-1:0] sat_part(input logic [N_W-1:0] mag, input logic neg);
    logic [SW-1:0] v;
    logic [EW-1:0] e;
    v = neg ? -{1'b0, mag} : {1'b0, mag};
    e = {{(EW-SW){v[SW-1]}}, v};
    if ($signed(e) > $signed(SAT_MAX)) begin
      sat_part = SAT_MAX[OUT_W-1:0];
    end else if ($signed(e) < $signed(SAT_MIN)) begin
      sat_part = SAT_MIN[OUT_W-1:0];
    end else begin
      sat_part = e[OUT_W-1:0];
    end
  endfunction

  logic             d_neg1, d_neg2;
  root_kind_t       d_kind;
  logic [OUT_W-1:0] r1_nxt, i1_nxt, r2_nxt, i2_nxt;

  assign d_neg1 = dv_side[KIND_W+1];
  assign d_neg2 = dv_side[KIND_W];
  assign d_kind = root_kind_t'(dv_side[KIND_W-1:0]);

  always_comb begin
    r1_nxt = '0;
    i1_nxt = '0;
    r2_nxt = '0;
    i2_nxt = '0;
    case (d_kind)
      KIND_REAL: begin
        r1_nxt = sat_part(dv_q1, d_neg1);
        r2_nxt = sat_part(dv_q2, d_neg2);
      end
      KIND_COMPLEX: begin
        r1_nxt = sat_part(dv_q1, d_neg1);
        r2_nxt = r1_nxt;
        i1_nxt = sat_part(dv_q2, d_neg2);
        i2_nxt = sat_part(dv_q2, !d_neg2);
      end
      default: begin
      end
    endcase
  end

  logic             out_vld_r;
  logic [OUT_W-1:0] r1_r, i1_r, r2_r, i2_r;
  root_kind_t       kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r   <= r1_nxt;
      i1_r   <= i1_nxt;
      r2_r   <= r2_nxt;
      i2_r   <= i2_nxt;
      kind_r <= d_kind;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OD_W'({i2_r, r2_r, i1_r, r1_r});
  assign out_tuser  = kind_r;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import qrs_pkg::*;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int IN_W = ((3*CW+7)/8)*8;
  localparam int OD_W = ((4*OUT_W+7)/8)*8;
  localparam int LATENCY = 72;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] a;
  } coef_t;

  typedef struct {
    logic signed [OUT_W-1:0] r1_re;
    logic signed [OUT_W-1:0] r1_im;
    logic signed [OUT_W-1:0] r2_re;
    logic signed [OUT_W-1:0] r2_im;
    root_kind_t kind;
  } roots_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OD_W-1:0] out_tdata;
  logic [KIND_W-1:0] out_tuser;

  coef_t pending_eqs[$];
  roots_t expected_roots[$];
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_cycles;
  int quiet_cycles;
  int errors;
  int eqs_sent;
  int roots_checked;
  int kind_seen[3];
  bit draining;
  bit in_taken;

  quadratic_root_solver_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] root;
    logic [127:0] bitv;
    root = 0;
    bitv = 128'd1 << 126;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp(input longint v);
    longint hi;
    hi = (longint'(1) <<< (OUT_W-1)) - 1;
    if (v > hi) return OUT_W'(hi);
    if (v < -hi - 1) return OUT_W'(-hi - 1);
    return OUT_W'(v);
  endfunction

  function automatic roots_t solve_quadratic(input coef_t q);
    roots_t r;
    longint a, b, c, d, den, nb, s, re, im;
    logic [127:0] mag;
    a = q.a;
    b = q.b;
    c = q.c;
    r.r1_im = 0;
    r.r2_im = 0;
    if (a == 0) begin
      r.r1_re = 0;
      r.r2_re = 0;
      r.kind = KIND_DEGEN;
      return r;
    end
    d = b * b - 4 * a * c;
    mag = (d < 0) ? -d : d;
    s = longint'(isqrt(mag << (2*FB)));
    den = 2 * a;
    nb = -b * (longint'(1) <<< FB);
    if (d >= 0) begin
      r.r1_re = clamp((nb + s) / den);
      r.r2_re = clamp((nb - s) / den);
      r.kind = KIND_REAL;
    end else begin
      re = nb / den;
      im = s / den;
      r.r1_re = clamp(re);
      r.r2_re = clamp(re);
      r.r1_im = clamp(im);
      r.r2_im = clamp(-im);
      r.kind = KIND_COMPLEX;
    end
    return r;
  endfunction

  function automatic coef_t random_eq();
    coef_t q;
    int mode;
    mode = $urandom_range(0, 9);
    q = coef_t'(IN_W'({$urandom, $urandom}));
    if (mode < 3) begin
      q.a = CW'($signed($urandom_range(0, 40)) - 20);
      q.b = CW'($signed($urandom_range(0, 200)) - 100);
      q.c = CW'($signed($urandom_range(0, 200)) - 100);
    end else if (mode == 3) begin
      q.a = 0;
    end else if (mode == 4) begin
      q.a = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      q.c = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    return q;
  endfunction

  task automatic add_eq(input int a, input int b, input int c);
    coef_t q;
    q.a = CW'(a);
    q.b = CW'(b);
    q.c = CW'(c);
    pending_eqs.push_back(q);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_eqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tdata <= IN_W'(pending_eqs.pop_front());
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    roots_t exp_r;
    roots_t got;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_tvalid && in_tready) begin
        expected_roots.push_back(solve_quadratic(coef_t'(in_tdata[3*CW-1:0])));
        eqs_sent <= eqs_sent + 1;
      end
      if (out_tvalid && out_tready) begin
        got.r1_re = out_tdata[OUT_W-1:0];
        got.r1_im = out_tdata[2*OUT_W-1:OUT_W];
        got.r2_re = out_tdata[3*OUT_W-1:2*OUT_W];
        got.r2_im = out_tdata[4*OUT_W-1:3*OUT_W];
        got.kind = root_kind_t'(out_tuser);
        if (expected_roots.size() == 0) begin
          $error("unexpected result with no request outstanding");
          errors++;
        end else begin
          exp_r = expected_roots.pop_front();
          roots_checked <= roots_checked + 1;
          if (exp_r.kind <= KIND_DEGEN) kind_seen[exp_r.kind]++;
          if (got.r1_re !== exp_r.r1_re) begin
            $error("root_one_real expected %0d got %0d", exp_r.r1_re, got.r1_re);
            errors++;
          end
          if (got.r1_im !== exp_r.r1_im) begin
            $error("root_one_imag expected %0d got %0d", exp_r.r1_im, got.r1_im);
            errors++;
          end
          if (got.r2_re !== exp_r.r2_re) begin
            $error("root_two_real expected %0d got %0d", exp_r.r2_re, got.r2_re);
            errors++;
          end
          if (got.r2_im !== exp_r.r2_im) begin
            $error("root_two_imag expected %0d got %0d", exp_r.r2_im, got.r2_im);
            errors++;
          end
          if (got.kind !== exp_r.kind) begin
            $error("root_kind expected %0d got %0d", exp_r.kind, got.kind);
            errors++;
          end
        end
      end
      if (quiet_cycles > WATCHDOG) begin
        $display("watchdog expired with %0d results outstanding", expected_roots.size());
        $display("[quadratic_root_solver_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic wait_sent();
    while (pending_eqs.size() != 0 || in_tvalid) @(posedge clk);
  endtask

  task automatic wait_drained();
    wait_sent();
    while (expected_roots.size() != 0) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    repeat (n) pending_eqs.push_back(random_eq());
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 0;
    quiet_cycles = 0;
    errors = 0;
    eqs_sent = 0;
    roots_checked = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_eq(1, -3, 2);
    add_eq(1, 2, 1);
    add_eq(1, 0, 1);
    add_eq(0, 5, 7);
    add_eq(0, -32768, 32767);
    add_eq(-1, 0, 4);
    add_eq(2, 3, 5);
    add_eq(32767, 32767, 32767);
    add_eq(-32768, -32768, -32768);
    add_eq(-32768, 32767, 32767);
    add_eq(32767, -32768, -32768);
    add_eq(1, -32768, 32767);
    add_eq(1, 32767, -32768);
    add_eq(-32768, 0, 32767);
    add_eq(-1, -32768, 0);
    add_eq(1, 0, 0);
    add_eq(-1, 0, -1);
    add_eq(1, 0, -32768);
    add_eq(-32768, 1, -32768);
    add_eq(3, -7, -11);
    wait_drained();

    // Long receiver hold-off so the pipeline fills and backpressures the input.
    hold_off_cycles = 400;
    queue_random(200);
    wait_drained();

    send_idle_pct = 32;
    recv_idle_pct = 65;
    queue_random(450);
    wait_drained();
    repeat (20) @(posedge clk);

    send_idle_pct = 65;
    recv_idle_pct = 32;
    queue_random(450);
    wait_sent();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(400);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d and checked %0d equations: %0d real, %0d complex, %0d degenerate.",
             eqs_sent, roots_checked, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("Covered coefficient extremes, backpressure and random idle on both sides.");
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("[quadratic_root_solver_unit] OK");
    end else begin
      $display("[quadratic_root_solver_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/qrs_pkg.sv
rtl/qrs_isqrt_pipe.sv
rtl/qrs_div_pipe.sv
rtl/quadratic_root_solver_unit.sv
sim/tb_top.sv
